// ----- rtl/ppg_pkg.sv -----
// shared types, register codes, palette and helpers of the pattern pixel generator
`timescale 1ns / 1ps

package ppg_pkg;

	typedef enum logic [1:0] {
		REG_PATTERN_STEP  = 2'd0,
		REG_CHECKER_CELLS = 2'd1,
		REG_STRIPE_BANDS  = 2'd2,
		REG_RING_COUNT    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_CHECKER = 2'd0,
		KIND_STRIPES = 2'd1,
		KIND_RINGS   = 2'd2
	} kind_t;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	localparam int PIX_W  = 7;
	localparam int SUM_W  = 8;
	localparam int DATA_W = 8;
	localparam int RING_W = 7;
	localparam int RC2_W  = 14;
	localparam int RGB_W  = 24;

	localparam int CHECKER_CELLS_RST = 8;
	localparam int STRIPE_BANDS_RST  = 10;
	localparam int RING_COUNT_RST    = 6;

	localparam logic [RGB_W-1:0] PALETTE [0:2][0:1] = '{
		'{24'hFF7300, 24'h26D933},
		'{24'hD91A26, 24'hF2D933},
		'{24'h1A8CF2, 24'hE6E6F2}
	};

	// exact for every 8-bit value
	function automatic logic [6:0] div3_u8(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd171;
		return p[15:9];
	endfunction

	function automatic logic [1:0] mod3_u8(input logic [7:0] v);
		logic [6:0] q;
		logic [7:0] r;
		q = div3_u8(v);
		r = v - (8'(q) * 8'd3);
		return r[1:0];
	endfunction

	function automatic logic [RGB_W-1:0] palette_rgb(input logic [1:0] pal, input logic sel);
		logic [RGB_W-1:0] rgb;
		case (pal)
			2'd0:    rgb = PALETTE[0][sel];
			2'd1:    rgb = PALETTE[1][sel];
			2'd2:    rgb = PALETTE[2][sel];
			default: rgb = PALETTE[0][sel];
		endcase
		return rgb;
	endfunction

endpackage

// ----- rtl/procedural_pattern_pixel_generator.sv -----
// top level of the procedural pattern pixel generator
`timescale 1ns / 1ps

// Procedural pattern pixel generator: gives the RGB colour of one pixel of a square
// SIDE x SIDE test texture (checkerboard, diagonal stripes or concentric rings).
// Input: a transaction is taken at a rising edge with start high and busy low,
// carrying pixel_x, pixel_y and plane_b. One pixel is taken every cycle unless busy.
// Output: every transaction gives one result on red/green/blue with done high for
// exactly one cycle; the receiver cannot stall it. The pipeline depth is set by
// the ring lane, where KW is the width of the ring index (KW = 8 for SIDE = 128):
// three stages of squaring and scaling, then one stage per ring index bit of a
// restoring square root; the cell and band lanes divide one quotient bit a stage.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. A write to the
// cell or band count starts a restoring divide of SIDE by the count, one bit a
// cycle; busy is high and cfg_ready low meanwhile. Pattern
// step and ring count writes take effect at once.
// Reset clears the pipeline, the registers to their reset values and the divider.
module procedural_pattern_pixel_generator #(
	parameter int SIDE = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ppg_pkg::PIX_W-1:0]          pixel_x,
	input  logic [ppg_pkg::PIX_W-1:0]          pixel_y,
	input  logic                               plane_b,
	output logic                               done,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  ppg_pkg::cfg_reg_t                  cfg_index,
	input  logic [ppg_pkg::DATA_W-1:0]         cfg_data
);

	import ppg_pkg::*;

	localparam int SW    = $clog2(SIDE + 1);
	localparam int CNT_W = $clog2(SW);
	localparam int TW    = ((SW > SUM_W) ? SW : SUM_W) + 1;
	localparam int DMAX  = (SIDE >= 127) ? SIDE : 254 - SIDE;
	localparam int DW    = $clog2(DMAX + 1);
	localparam int QW    = 2 * DW + 1;
	localparam int MW    = RC2_W + QW;
	localparam int KMAX  = (127 * 3 * DMAX) / (2 * SIDE) + 1;
	localparam int KW    = $clog2(KMAX + 1);
	localparam int CW0   = 2 * (KW + SW) + 2;
	localparam int CW    = (CW0 > MW) ? CW0 : MW;
	localparam int EW    = SW + SUM_W;
	localparam int DIV_LAST = SUM_W + 1;
	localparam int P     = KW + 2;
	localparam int LAT   = P + 1;

	localparam int CHK_Q = SIDE / CHECKER_CELLS_RST;
	localparam int BND_Q = SIDE / STRIPE_BANDS_RST;
	localparam logic [SW-1:0] CHK_SIZE_RST = SW'((CHK_Q > 0) ? CHK_Q : 1);
	localparam logic [SW-1:0] BND_SIZE_RST = SW'((BND_Q > 0) ? BND_Q : 1);
	localparam logic [RC2_W-1:0] RC2_RST   = RC2_W'(RING_COUNT_RST * RING_COUNT_RST);
	localparam logic [SW-1:0] SIDE_BITS    = SW'(SIDE);
	localparam logic [CW-1:0] S2           = CW'(SIDE * SIDE);
	localparam logic [TW-1:0] SIDE_T       = TW'(SIDE);

	// configuration state
	kind_t             kind_q;
	logic [1:0]        pal_q;
	logic [RC2_W-1:0]  rc2_q;
	logic [SW-1:0]     chk_size_q;
	logic [SW-1:0]     band_size_q;

	// size divider
	div_state_t        state_q, state_nx;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [7:0]        div_rem_q;
	logic [7:0]        div_den_q;
	logic [SW-1:0]     div_quo_q;
	logic              div_tgt_q;
	logic [8:0]        div_rem2;
	logic              div_ge;
	logic [7:0]        div_rem_nx;
	logic [SW-1:0]     div_quo_nx;
	logic [SW-1:0]     div_size_nx;
	logic              div_last;
	logic              cfg_wr;
	logic              size_wr;

	assign cfg_wr  = cfg_valid && cfg_ready;
	assign size_wr = cfg_wr && (cfg_index == REG_CHECKER_CELLS || cfg_index == REG_STRIPE_BANDS);

	assign div_rem2    = {div_rem_q, SIDE_BITS[div_cnt_q]};
	assign div_ge      = div_rem2 >= {1'b0, div_den_q};
	assign div_rem_nx  = div_ge ? 8'(div_rem2 - {1'b0, div_den_q}) : div_rem2[7:0];
	assign div_quo_nx  = SW'({div_quo_q, div_ge});
	assign div_size_nx = (div_quo_nx == '0) ? SW'(1) : div_quo_nx;

	always_comb begin
		state_nx  = state_q;
		div_last  = 1'b0;
		busy      = 1'b0;
		cfg_ready = 1'b1;
		case (state_q)
			DIV_IDLE: begin
				if (size_wr) begin
					state_nx = DIV_RUN;
				end
			end
			DIV_RUN: begin
				busy      = 1'b1;
				cfg_ready = 1'b0;
				if (div_cnt_q == '0) begin
					div_last = 1'b1;
					state_nx = DIV_IDLE;
				end
			end
			default: state_nx = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DIV_IDLE;
			kind_q      <= KIND_CHECKER;
			pal_q       <= 2'd0;
			rc2_q       <= RC2_RST;
			chk_size_q  <= CHK_SIZE_RST;
			band_size_q <= BND_SIZE_RST;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) begin
				case (cfg_index)
					REG_PATTERN_STEP: begin
						kind_q <= kind_t'(mod3_u8(cfg_data));
						pal_q  <= mod3_u8({1'b0, div3_u8(cfg_data)});
					end
					REG_RING_COUNT: begin
						rc2_q <= RC2_W'(cfg_data[RING_W-1:0]) * RC2_W'(cfg_data[RING_W-1:0]);
					end
					default: ;
				endcase
			end
			if (div_last) begin
				if (div_tgt_q) begin
					band_size_q <= div_size_nx;
				end else begin
					chk_size_q <= div_size_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (size_wr) begin
			div_den_q <= (cfg_data == '0) ? 8'd1 : cfg_data;
			div_tgt_q <= (cfg_index == REG_STRIPE_BANDS);
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_cnt_q <= CNT_W'(SW - 1);
		end else if (state_q == DIV_RUN) begin
			div_rem_q <= div_rem_nx;
			div_quo_q <= div_quo_nx;
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
	end

	// pixel pipeline
	logic              accept;
	logic [SW-1:0]     div_size;
	logic [TW-1:0]     tx, ty;
	logic [DW-1:0]     adx, ady;

	logic              vld_s   [1:P];
	logic              plane_s [1:P];
	logic [SUM_W-1:0]  ra_s    [1:DIV_LAST-1];
	logic [SUM_W-1:0]  rb_s    [1:DIV_LAST-1];
	logic              dpar_s  [DIV_LAST:P];
	logic [2*DW-1:0]   dx2_s1, dy2_s1;
	logic [QW-1:0]     q_s2;
	logic [MW-1:0]     m_s3;
	logic [CW-1:0]     rrem_s  [4:P];
	logic [CW-1:0]     rt_s    [4:P];

	logic [CW-1:0]     fin_delta;
	logic              ring_bit;
	logic              parity;
	logic              done_q;
	logic [RGB_W-1:0]  rgb_q;

	assign accept   = start && !busy;
	assign div_size = (kind_q == KIND_CHECKER) ? chk_size_q : band_size_q;

	assign tx  = TW'({pixel_x, 1'b0});
	assign ty  = TW'({pixel_y, 1'b0});
	assign adx = DW'((tx >= SIDE_T) ? tx - SIDE_T : SIDE_T - tx);
	assign ady = DW'((ty >= SIDE_T) ? ty - SIDE_T : SIDE_T - ty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= P; k++) begin
				vld_s[k] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_s[1] <= accept;
			for (int k = 2; k <= P; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			done_q <= vld_s[P];
		end
	end

	always_ff @(posedge clk) begin
		plane_s[1] <= plane_b;
		for (int k = 2; k <= P; k++) begin
			plane_s[k] <= plane_s[k-1];
		end
		ra_s[1] <= (kind_q == KIND_CHECKER) ? SUM_W'(pixel_x) : SUM_W'(pixel_x) + SUM_W'(pixel_y);
		rb_s[1] <= SUM_W'(pixel_y);
		dx2_s1  <= (2*DW)'(adx) * (2*DW)'(adx);
		dy2_s1  <= (2*DW)'(ady) * (2*DW)'(ady);
		q_s2    <= QW'(dx2_s1) + QW'(dy2_s1);
		m_s3    <= MW'(rc2_q) * MW'(q_s2);
	end

	for (genvar k = DIV_LAST + 1; k <= P; k++) begin : g_dpar
		always_ff @(posedge clk) begin
			dpar_s[k] <= dpar_s[k-1];
		end
	end

	// cell and band lanes: one restoring quotient bit per stage, parity of the last
	for (genvar k = 2; k <= DIV_LAST; k++) begin : g_div
		localparam int B = DIV_LAST - k;
		logic [EW-1:0] dsh;
		logic [EW-1:0] va, vb;
		logic          ga, gb;

		assign dsh = EW'(div_size) << B;
		assign va  = EW'(ra_s[k-1]);
		assign vb  = EW'(rb_s[k-1]);
		assign ga  = va >= dsh;
		assign gb  = vb >= dsh;

		if (k < DIV_LAST) begin : g_step
			always_ff @(posedge clk) begin
				ra_s[k] <= ga ? SUM_W'(va - dsh) : ra_s[k-1];
				rb_s[k] <= gb ? SUM_W'(vb - dsh) : rb_s[k-1];
			end
		end else begin : g_end
			always_ff @(posedge clk) begin
				dpar_s[k] <= (kind_q == KIND_CHECKER) ? (ga ^ gb) : ga;
			end
		end
	end

	// ring lane: largest k with (k*SIDE)^2 <= m, one bit per stage, t tracks k*SIDE^2
	for (genvar k = 4; k <= P; k++) begin : g_sqrt
		localparam int B = KW + 3 - k;
		logic [CW-1:0] rem_in, t_in, delta;
		logic          ge;

		if (k == 4) begin : g_first
			assign rem_in = CW'(m_s3);
			assign t_in   = '0;
		end else begin : g_next
			assign rem_in = rrem_s[k-1];
			assign t_in   = rt_s[k-1];
		end

		assign delta = (t_in << (B + 1)) + (S2 << (2 * B));
		assign ge    = rem_in >= delta;

		always_ff @(posedge clk) begin
			rrem_s[k] <= ge ? rem_in - delta : rem_in;
			rt_s[k]   <= ge ? t_in + (S2 << B) : t_in;
		end
	end

	assign fin_delta = (rt_s[P] << 1) + S2;
	assign ring_bit  = rrem_s[P] >= fin_delta;
	assign parity    = (kind_q == KIND_RINGS) ? ring_bit : dpar_s[P];

	always_ff @(posedge clk) begin
		rgb_q <= palette_rgb(pal_q, parity ^ plane_s[P]);
	end

	assign done  = done_q;
	assign red   = rgb_q[23:16];
	assign green = rgb_q[15:8];
	assign blue  = rgb_q[7:0];

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	a_busy_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cfg_valid && cfg_ready))
		else $error("divider started without a configuration write");

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (chk_size_q != '0) && (band_size_q != '0))
		else $error("cell or band size is zero");

endmodule
